// ===== sv/ssm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the streaming substring matcher.
// Used by every module of the block; depends on nothing else.

package ssm_pkg;

    // Configuration register indexes. The port decodes them from paddr[4:3].
    localparam int unsigned REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_FOLD_CASE    = 2'd3;

    // Register widths fixed by the register map.
    localparam int unsigned DATA_W     = 64;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PAT_BYTES  = 16;
    localparam int unsigned PAT_W      = PAT_BYTES * BYTE_W;

    // ASCII upper-case range and the distance to lower case.
    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET   = 8'h20;

    // Pattern configuration seen by the compare front end.
    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic             fold_case;
    } t_cfg;

    // Occupancy flags of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Maps A..Z to a..z when folding is enabled.
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic              en);
        logic [BYTE_W-1:0] r;
        r = b;
        if (en && (b inside {[ASCII_UPPER_A:ASCII_UPPER_Z]})) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== sv/ssm_front.sv =====
`timescale 1ns / 1ps
// Front end of the substring matcher: folds the text byte and compares it
// against every pattern byte at once. Depends on ssm_pkg.

module ssm_front #(
    parameter int unsigned MAX_PATTERN = 16
) (
    input  ssm_pkg::t_cfg                    i_cfg,
    input  logic [ssm_pkg::BYTE_W-1:0]       i_text_byte,
    output logic [MAX_PATTERN-1:0]           o_eq
);

    logic [ssm_pkg::BYTE_W-1:0] w_text;

    // Fold the text byte once, then compare against each folded pattern byte.
    assign w_text = ssm_pkg::fold_byte(i_text_byte, i_cfg.fold_case);

    always_comb begin
        for (int j = 0; j < int'(MAX_PATTERN); j++) begin
            o_eq[j] = (ssm_pkg::fold_byte(i_cfg.pattern[j*ssm_pkg::BYTE_W +: ssm_pkg::BYTE_W],
                                          i_cfg.fold_case) == w_text);
        end
    end

endmodule

// ===== sv/ssm_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue that decouples the compare front end from the match back end.
// Depends on ssm_pkg for its status struct.

module ssm_fifo #(
    parameter int unsigned WIDTH = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output ssm_pkg::t_q_status   o_status
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer and occupancy updates.
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset; entries are only read once written.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== sv/ssm_back.sv =====
`timescale 1ns / 1ps
// Back end of the substring matcher: shift-and update, sticky found flag and
// the output register. Depends on ssm_pkg.

module ssm_back #(
    parameter int unsigned MAX_PATTERN = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ssm_pkg::t_q_status          i_q_status,
    input  logic [MAX_PATTERN-1:0]      i_eq,
    input  logic                        i_last,
    input  logic [ssm_pkg::LEN_W-1:0]   i_length,
    input  logic                        i_ready,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic                        o_found,
    output logic                        o_result_last
);

    logic [MAX_PATTERN-1:0] r_bits, n_bits;
    logic                   r_sticky, n_sticky;
    logic                   r_out_valid;
    logic                   r_found;
    logic                   r_last;
    logic [MAX_PATTERN-1:0] w_sel;
    logic                   w_hit;

    // Take an entry whenever one waits and the output register is free or drains.
    assign o_pop = !i_q_status.empty && (!r_out_valid || i_ready);

    // One-hot select of the bit that marks a full match; lengths above the
    // maximum select the top bit, and a length of zero selects nothing.
    always_comb begin
        for (int j = 0; j < int'(MAX_PATTERN); j++) begin
            w_sel[j] = (i_length == ssm_pkg::LEN_W'(j + 1));
        end
        if (i_length > ssm_pkg::LEN_W'(MAX_PATTERN)) begin
            w_sel[MAX_PATTERN-1] = 1'b1;
        end
    end

    // Shift-and step: extend every partial match by one byte, start a new one.
    always_comb begin
        n_bits   = MAX_PATTERN'({r_bits, 1'b1}) & i_eq;
        w_hit    = |(n_bits & w_sel);
        n_sticky = r_sticky | w_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits      <= '0;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_bits      <= i_last ? '0 : n_bits;
                r_sticky    <= i_last ? 1'b0 : n_sticky;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each transfer out of the queue.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_found <= n_sticky;
            r_last  <= i_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_found;
    assign o_result_last = r_last;

endmodule

// ===== sv/streaming_substring_matcher.sv =====
`timescale 1ns / 1ps
// Streaming substring matcher top level: register port, front end, queue and
// back end. Depends on ssm_pkg, ssm_front, ssm_fifo and ssm_back.

// The block takes one text byte per cycle and returns one result per byte, a
// sticky found flag plus a copy of the last marker, at a sustained rate of
// one byte per cycle while results are taken. A byte passes through the
// two-entry queue behind the compare front end, then the output register of
// the shift-and back end. The queue lets input transfers continue while a
// result waits to be taken. Program the pattern, its length (0 never
// matches, above MAX_PATTERN acts as MAX_PATTERN) and the case-fold bit only
// while no text is in flight; the match state clears after every byte
// marked last.

module streaming_substring_matcher #(
    parameter int unsigned MAX_PATTERN = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Text input channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ssm_pkg::BYTE_W-1:0]     i_text_byte,
    input  logic                           i_text_last,
    // Result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_found,
    output logic                           o_result_last,
    // Register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssm_pkg::ADDR_W-1:0]     paddr,
    input  logic [ssm_pkg::DATA_W-1:0]     pwdata,
    output logic [ssm_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    localparam int unsigned Q_W = MAX_PATTERN + 1;

    logic [ssm_pkg::DATA_W-1:0]          r_pat_low;
    logic [ssm_pkg::DATA_W-1:0]          r_pat_high;
    logic [ssm_pkg::LEN_W-1:0]           r_length;
    logic                                r_fold_case;
    logic [ssm_pkg::REG_IDX_W-1:0]       w_reg_idx;
    logic                                w_cfg_wr;
    ssm_pkg::t_cfg                       w_cfg;
    ssm_pkg::t_q_status                  w_q_status;
    logic [MAX_PATTERN-1:0]              w_eq;
    logic [Q_W-1:0]                      w_q_out;
    logic                                w_push;
    logic                                w_pop;

    // Register port: writes land in the access phase, reads are combinational.
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ssm_pkg::ADDR_W-1 -: ssm_pkg::REG_IDX_W];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low   <= '0;
            r_pat_high  <= '0;
            r_length    <= '0;
            r_fold_case <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                ssm_pkg::REG_PATTERN_LOW:  r_pat_low   <= pwdata;
                ssm_pkg::REG_PATTERN_HIGH: r_pat_high  <= pwdata;
                ssm_pkg::REG_PATTERN_LEN:  r_length    <= pwdata[ssm_pkg::LEN_W-1:0];
                ssm_pkg::REG_FOLD_CASE:    r_fold_case <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            ssm_pkg::REG_PATTERN_LOW:  prdata = r_pat_low;
            ssm_pkg::REG_PATTERN_HIGH: prdata = r_pat_high;
            ssm_pkg::REG_PATTERN_LEN:  prdata = ssm_pkg::DATA_W'(r_length);
            ssm_pkg::REG_FOLD_CASE:    prdata = ssm_pkg::DATA_W'(r_fold_case);
            default:                   prdata = '0;
        endcase
    end

    assign w_cfg.pattern   = {r_pat_high, r_pat_low};
    assign w_cfg.fold_case = r_fold_case;

    // Front end: classify each byte into its pattern-compare vector.
    ssm_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_cfg       (w_cfg),
        .i_text_byte (i_text_byte),
        .o_eq        (w_eq)
    );

    assign o_ready = !w_q_status.full;
    assign w_push  = i_valid && o_ready;

    // Queue between front and back.
    ssm_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   ({i_text_last, w_eq}),
        .i_pop    (w_pop),
        .o_data   (w_q_out),
        .o_status (w_q_status)
    );

    // Back end: shift-and state and the result register.
    ssm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_eq          (w_q_out[MAX_PATTERN-1:0]),
        .i_last        (w_q_out[MAX_PATTERN]),
        .i_length      (r_length),
        .i_ready       (i_ready),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_result_last (o_result_last)
    );

`ifndef NO_ASSERTIONS
    // The queue cannot report full and empty at the same time.
    a_q_status_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue reports full and empty together");

    // With nothing queued and nothing held, no result may appear next cycle.
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_status.empty && !o_valid) |=> !o_valid)
        else $error("result appeared without a queued byte");

    // A byte entering an idle block produces its result after the queue and the output register.
    a_idle_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_q_status.empty && !o_valid) |=> ##1 o_valid)
        else $error("result missing two cycles after transfer into idle block");
`endif

endmodule

// ===== bench/streaming_substring_matcher_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for streaming_substring_matcher: directed special cases, then
// random texts under several handshake idle mixes. Depends on ssm_pkg and the matcher RTL.

module streaming_substring_matcher_tb;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned HOLD_OFF_CYCLES = 150;
    localparam int unsigned PHASE_BYTES     = 80;

    // One result transfer as the predictor expects it.
    typedef struct packed {
        logic found;
        logic last;
    } t_match_result;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_valid       = 1'b0;
    logic                           o_ready;
    logic [ssm_pkg::BYTE_W-1:0]     i_text_byte   = '0;
    logic                           i_text_last   = 1'b0;
    logic                           o_valid;
    logic                           i_ready       = 1'b0;
    logic                           o_found;
    logic                           o_result_last;
    logic                           psel          = 1'b0;
    logic                           penable       = 1'b0;
    logic                           pwrite        = 1'b0;
    logic [ssm_pkg::ADDR_W-1:0]     paddr         = '0;
    logic [ssm_pkg::DATA_W-1:0]     pwdata        = '0;
    logic [ssm_pkg::DATA_W-1:0]     prdata;
    logic                           pready;

    // Mirror of the configuration registers and the match state.
    logic [ssm_pkg::DATA_W-1:0]     pat_low    = '0;
    logic [ssm_pkg::DATA_W-1:0]     pat_high   = '0;
    logic [ssm_pkg::LEN_W-1:0]      pat_len    = '0;
    logic                           fold_on    = 1'b0;
    logic [ssm_pkg::PAT_BYTES-1:0]  match_vec  = '0;
    logic                           found_flag = 1'b0;

    t_match_result expected_results[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_left          = 0;
    int idle_cycles        = 0;
    int failures           = 0;
    int results_checked    = 0;
    int bytes_sent         = 0;
    int texts_sent         = 0;
    int texts_found        = 0;

    // Bytes at and just outside the edges of the letter ranges, where case folding starts and stops.
    logic [ssm_pkg::BYTE_W-1:0] fold_borders [6] = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h7B};

    streaming_substring_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_text_last   (i_text_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_result_last (o_result_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("Mismatch: %s", msg);
        end
    endtask

    function automatic logic [ssm_pkg::BYTE_W-1:0] lower_letter(
        input logic [ssm_pkg::BYTE_W-1:0] b);
        if (fold_on && b >= ssm_pkg::ASCII_UPPER_A && b <= ssm_pkg::ASCII_UPPER_Z) begin
            return b + ssm_pkg::CASE_OFFSET;
        end
        return b;
    endfunction

    // Shift-and step: advances the partial-match vector and the sticky flag by one byte.
    function automatic t_match_result predict_match(input logic [ssm_pkg::BYTE_W-1:0] b,
                                                    input logic last);
        logic [ssm_pkg::PAT_W-1:0]     pat;
        logic [ssm_pkg::PAT_BYTES-1:0] eq;
        logic [ssm_pkg::BYTE_W-1:0]    c;
        logic [ssm_pkg::LEN_W-1:0]     eff_len;
        t_match_result                 r;
        int                            j;
        pat = {pat_high, pat_low};
        c   = lower_letter(b);
        eq  = '0;
        for (j = 0; j < ssm_pkg::PAT_BYTES; j++) begin
            eq[j] = (lower_letter(pat[j*ssm_pkg::BYTE_W +: ssm_pkg::BYTE_W]) == c);
        end
        match_vec = ((match_vec << 1) | ssm_pkg::PAT_BYTES'(1)) & eq;
        // Lengths above the vector size act as the full size.
        eff_len = (pat_len > ssm_pkg::PAT_BYTES) ? ssm_pkg::LEN_W'(ssm_pkg::PAT_BYTES)
                                                 : pat_len;
        if (eff_len != 0 && match_vec[eff_len - 1]) begin
            found_flag = 1'b1;
        end
        r.found = found_flag;
        r.last  = last;
        if (last) begin
            match_vec  = '0;
            found_flag = 1'b0;
        end
        return r;
    endfunction

    // Result side: check each transfer against the oldest expectation, then pick ready.
    always @(posedge i_clk) begin
        t_match_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                note_failure($sformatf("result with nothing expected: found=%0b last=%0b",
                                       o_found, o_result_last));
            end else begin
                want = expected_results.pop_front();
                if (want.found !== o_found) begin
                    note_failure($sformatf("found expected %0b actual %0b (result %0d)",
                                           want.found, o_found, results_checked));
                end
                if (want.last !== o_result_last) begin
                    note_failure($sformatf("result_last expected %0b actual %0b (result %0d)",
                                           want.last, o_result_last, results_checked));
                end
                if (want.found && want.last) begin
                    texts_found++;
                end
            end
        end
        // A long hold-off overrides the random stalls.
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Register write: setup cycle, access cycle, then the bus is released before the task returns.
    task automatic write_reg(input logic [ssm_pkg::REG_IDX_W-1:0] idx,
                             input logic [ssm_pkg::DATA_W-1:0]    value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            ssm_pkg::REG_PATTERN_LOW:  pat_low  = value;
            ssm_pkg::REG_PATTERN_HIGH: pat_high = value;
            ssm_pkg::REG_PATTERN_LEN:  pat_len  = value[ssm_pkg::LEN_W-1:0];
            ssm_pkg::REG_FOLD_CASE:    fold_on  = value[0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drains the block: stops offering bytes, waits for every result back, then lets it settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_matcher(input logic [ssm_pkg::DATA_W-1:0] low,
                                   input logic [ssm_pkg::DATA_W-1:0] high,
                                   input logic [ssm_pkg::LEN_W-1:0]  len,
                                   input logic                       fold);
        wait_idle();
        write_reg(ssm_pkg::REG_PATTERN_LOW, low);
        write_reg(ssm_pkg::REG_PATTERN_HIGH, high);
        write_reg(ssm_pkg::REG_PATTERN_LEN, ssm_pkg::DATA_W'(len));
        write_reg(ssm_pkg::REG_FOLD_CASE, ssm_pkg::DATA_W'(fold));
    endtask

    // Offers one text byte, with random idle cycles first, and returns at its transfer.
    task automatic send_text_byte(input logic [ssm_pkg::BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        i_text_last <= last;
        expected_results.push_back(predict_match(b, last));
        bytes_sent++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_text(input logic [ssm_pkg::BYTE_W-1:0] txt[$]);
        int k;
        for (k = 0; k < txt.size(); k++) begin
            send_text_byte(txt[k], k == txt.size() - 1);
        end
        texts_sent++;
    endtask

    // Mostly four letters (a to d) in either case so partial matches are common.
    function automatic logic [ssm_pkg::BYTE_W-1:0] pick_text_byte();
        int unsigned                r;
        logic [ssm_pkg::BYTE_W-1:0] b;
        r = $urandom_range(9);
        if (r < 6) begin
            b = 8'h61 + 8'($urandom_range(3));
            if ($urandom_range(1)) begin
                b = b - ssm_pkg::CASE_OFFSET;
            end
        end else if (r == 6) begin
            b = fold_borders[$urandom_range(5)];
        end else begin
            b = 8'($urandom_range(1, 255));
        end
        return b;
    endfunction

    function automatic logic [ssm_pkg::BYTE_W-1:0] vary_case(
        input logic [ssm_pkg::BYTE_W-1:0] b);
        if (fold_on && $urandom_range(1) &&
            ((b >= ssm_pkg::ASCII_UPPER_A && b <= ssm_pkg::ASCII_UPPER_Z) ||
             (b >= ssm_pkg::ASCII_UPPER_A + ssm_pkg::CASE_OFFSET &&
              b <= ssm_pkg::ASCII_UPPER_Z + ssm_pkg::CASE_OFFSET))) begin
            return b ^ ssm_pkg::CASE_OFFSET;
        end
        return b;
    endfunction

    task automatic random_config();
        logic [ssm_pkg::PAT_W-1:0] pat;
        logic [ssm_pkg::LEN_W-1:0] len;
        int                        j;
        case ($urandom_range(9))
            0:       len = '0;
            1:       len = ssm_pkg::LEN_W'(ssm_pkg::PAT_BYTES);
            2:       len = ssm_pkg::LEN_W'(1);
            3:       len = ssm_pkg::LEN_W'($urandom_range(9, 15));
            default: len = ssm_pkg::LEN_W'($urandom_range(2, 6));
        endcase
        // Bytes past the length are arbitrary, zero included.
        for (j = 0; j < ssm_pkg::PAT_BYTES; j++) begin
            pat[j*ssm_pkg::BYTE_W +: ssm_pkg::BYTE_W] =
                (j < len) ? pick_text_byte() : 8'($urandom_range(255));
        end
        program_matcher(pat[ssm_pkg::DATA_W-1:0], pat[ssm_pkg::PAT_W-1:ssm_pkg::DATA_W], len,
                        1'($urandom_range(1)));
    endtask

    // A short text, usually with the pattern planted somewhere in it.
    task automatic random_text();
        logic [ssm_pkg::BYTE_W-1:0] txt[$];
        logic [ssm_pkg::PAT_W-1:0]  pat;
        int                         n;
        int                         pos;
        int                         k;
        n   = $urandom_range(1, 20);
        pat = {pat_high, pat_low};
        for (k = 0; k < n; k++) begin
            txt.push_back(pick_text_byte());
        end
        if (pat_len != 0 && $urandom_range(99) < 60) begin
            pos = $urandom_range(0, n);
            for (k = 0; k < pat_len && k < ssm_pkg::PAT_BYTES; k++) begin
                txt.insert(pos + k, vary_case(pat[k*ssm_pkg::BYTE_W +: ssm_pkg::BYTE_W]));
            end
        end
        send_text(txt);
    endtask

    // Reset values: length zero never matches, even a zero byte against the zero pattern.
    task automatic test_zero_length();
        logic [ssm_pkg::BYTE_W-1:0] txt[$];
        txt = '{8'h00, 8'hFF};
        send_text(txt);
    endtask

    // A zero pattern byte only matches a zero text byte.
    task automatic test_zero_pattern_byte();
        logic [ssm_pkg::BYTE_W-1:0] txt[$];
        program_matcher('0, '0, ssm_pkg::LEN_W'(1), 1'b0);
        txt = '{8'h80, 8'h00};
        send_text(txt);
    endtask

    // Exact compare hits, then misses on case; with folding on the same text hits.
    task automatic test_exact_and_folded();
        logic [ssm_pkg::BYTE_W-1:0] txt[$];
        program_matcher(64'h0000_0000_0063_4261, '1, ssm_pkg::LEN_W'(3), 1'b0);
        txt = '{8'h61, 8'h42, 8'h63, 8'h64};
        send_text(txt);
        txt = '{8'h41, 8'h62, 8'h43};
        send_text(txt);
        wait_idle();
        write_reg(ssm_pkg::REG_FOLD_CASE, ssm_pkg::DATA_W'(1));
        send_text(txt);
    endtask

    // Length above the maximum acts as sixteen; the upper pattern half changes mid-text
    // while the partial-match vector is kept.
    task automatic test_long_pattern_midtext();
        int k;
        program_matcher(64'h5A5A_5A5A_5A5A_5A5A, '1, 5'd31, 1'b1);
        for (k = 0; k < 8; k++) begin
            send_text_byte((k % 2) ? 8'h5A : 8'h7A, 1'b0);
        end
        wait_idle();
        write_reg(ssm_pkg::REG_PATTERN_HIGH, 64'h7A7A_7A7A_7A7A_7A7A);
        for (k = 0; k < 8; k++) begin
            send_text_byte((k % 2) ? 8'h7A : 8'h5A, k == 7);
        end
        texts_sent++;
    endtask

    // Random texts and patterns under four sender and receiver idle mixes.
    task automatic test_random_traffic();
        int sender_mix [4]   = '{0, 59, 0, 10};
        int receiver_mix [4] = '{0, 0, 59, 10};
        int mix;
        int start;
        int texts;
        for (mix = 0; mix < 4; mix++) begin
            sender_idle_pct    = sender_mix[mix];
            receiver_stall_pct = receiver_mix[mix];
            start = bytes_sent;
            texts = 0;
            while (bytes_sent - start < PHASE_BYTES) begin
                if (texts % 3 == 0) begin
                    random_config();
                end
                random_text();
                texts++;
            end
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering bytes.
    task automatic test_output_backpressure();
        int k;
        program_matcher(64'h0000_0000_0000_6261, '0, ssm_pkg::LEN_W'(2), 1'b0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          = HOLD_OFF_CYCLES;
        for (k = 0; k < 4; k++) begin
            random_text();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_length();
        test_zero_pattern_byte();
        test_exact_and_folded();
        test_long_pattern_midtext();
        test_random_traffic();
        test_output_backpressure();
        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d texts, %0d bytes and %0d checked results (%0d texts matched),",
                 texts_sent, bytes_sent, results_checked, texts_found);
        $display("across four idle mixes and one long output hold-off.");
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches in total", failures);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ssm_pkg.sv
sv/ssm_front.sv
sv/ssm_fifo.sv
sv/ssm_back.sv
sv/streaming_substring_matcher.sv
bench/streaming_substring_matcher_tb.sv
